FILE: hdl/lap3_pkg.sv
// ----------------------------------------------------------------------------
// lap3_pkg
// Shared types and constants of the 3x3 four-neighbour Laplacian filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lap3_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 10;
  localparam int CFG_IDX_W = 8;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
  // width that holds column + 1, row index and any frame dimension
  localparam int EXT_W     = ((COL_W + 1) > DIM_W) ?
                             (((COL_W + 1) > ROW_W) ? (COL_W + 1) : ROW_W) :
                             ((DIM_W > ROW_W) ? DIM_W : ROW_W);
  localparam int SUM_W     = PIX_W + 4;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(352);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(288);
  localparam logic signed [SUM_W-1:0] BIAS    = SUM_W'(127);
  localparam logic signed [SUM_W-1:0] PIX_MAX = SUM_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = CFG_IDX_W'(0),
    CFG_FRAME_HEIGHT = CFG_IDX_W'(1)
  } lap3_cfg_idx_t;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel_in;
  } lap3_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } lap3_out_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input int max_val);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > 32'(max_val)) begin
      res = DIM_W'(max_val);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/laplacian_3x3_image_filter.sv
// ----------------------------------------------------------------------------
// laplacian_3x3_image_filter
// Streaming 3x3 four-neighbour Laplacian with two line stores, bias and clamp.
// ----------------------------------------------------------------------------
// A result word is registered in the output register in the cycle after its pixel.
// Throughput: one word per cycle unless the output stalls; each line store has
//   one read port read one column ahead of the pixels, so no column ever waits.
// Reset: control state clears at once, frame 352 x 288; line stores are not
//   cleared, since row zero of every frame rewrites them before any read.
`default_nettype none

module laplacian_3x3_image_filter
  import lap3_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire lap3_in_t             in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      lap3_out_t            out_data,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  // Frame geometry, held in effective (clamped) form.
  logic [DIM_W-1:0] width_r, height_r;
  logic [EXT_W-1:0] w_x, h_x;

  // Position in the frame.
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [PIX_W-1:0] left_r;

  // Line stores: row above and centre row.
  logic [PIX_W-1:0] above_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] centre_mem [MAX_WIDTH];

  // Read-ahead window for the next column.
  logic [PIX_W-1:0] above_rd_r, centre_rd_r;
  logic             above_fwd_r, centre_fwd_r, right_zero_r;
  logic [PIX_W-1:0] above_fwd_val_r, centre_fwd_val_r;
  logic [PIX_W-1:0] centre_cur_r, col0_r;

  // Output register.
  logic             out_valid_r;
  lap3_out_t        out_data_r;

  logic             in_fire, cfg_fire, active, step, emit, wr_en, last_col;
  logic [EXT_W-1:0] col_x, col_inc, nxt_inc;
  logic [COL_W-1:0] nxt_col;
  logic [PIX_W-1:0] up, down, left, right, above_wr;
  logic [PIX_W-1:0] centre_cur_nxt;
  logic [DIM_W+1:0] pos_sum;
  logic signed [SUM_W-1:0] lap_sum;
  logic [PIX_W-1:0] lap_clamped;

  assign w_x = EXT_W'(width_r);
  assign h_x = EXT_W'(height_r);

  // ---- handshakes ---------------------------------------------------------
  // Take a new word whenever the output register is empty or being emptied.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Pixels count only until all rows are in; flush ticks only after that.
  assign active = in_data.func ? (EXT_W'(row_r) >= h_x) : (EXT_W'(row_r) < h_x);
  assign step   = in_fire && active;
  assign emit   = step && (row_r != '0);
  assign wr_en  = step && !in_data.func;

  // ---- column sequencing --------------------------------------------------
  assign col_x    = EXT_W'(col_r);
  assign col_inc  = col_x + EXT_W'(1);
  assign last_col = (col_inc >= w_x);
  assign nxt_col  = last_col ? '0 : col_inc[COL_W-1:0];
  assign nxt_inc  = EXT_W'(nxt_col) + EXT_W'(1);

  // ---- stencil taps -------------------------------------------------------
  // Forwarded values cover a read that hit the entry written in the same cycle.
  assign up    = above_fwd_r ? above_fwd_val_r : above_rd_r;
  assign right = right_zero_r ? '0 :
                 (centre_fwd_r ? centre_fwd_val_r : centre_rd_r);
  assign left  = (col_r == '0) ? '0 : left_r;
  assign down  = in_data.func ? '0 : in_data.pixel_in;

  // up + down + left + right - 4 * centre + bias, then clamp to a byte
  assign pos_sum = (DIM_W+2)'(up) + (DIM_W+2)'(down) +
                   (DIM_W+2)'(left) + (DIM_W+2)'(right);
  assign lap_sum = $signed(SUM_W'(pos_sum)) -
                   $signed(SUM_W'({centre_cur_r, 2'b00})) + BIAS;

  always_comb begin
    if (lap_sum < 0) begin
      lap_clamped = '0;
    end else if (lap_sum > PIX_MAX) begin
      lap_clamped = '1;
    end else begin
      lap_clamped = lap_sum[PIX_W-1:0];
    end
  end

  // Row zero pushes a zero row into the above store.
  assign above_wr = (row_r == '0) ? '0 : centre_cur_r;

  // Next centre: the right tap slides in, or column zero at a row wrap.
  always_comb begin
    if (!last_col) begin
      centre_cur_nxt = right;
    end else if ((col_r == '0) && !in_data.func) begin
      centre_cur_nxt = in_data.pixel_in;
    end else begin
      centre_cur_nxt = col0_r;
    end
  end

  // ---- line stores --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[col_r]  <= above_wr;
      centre_mem[col_r] <= in_data.pixel_in;
    end
  end

  // Read one column ahead: above at the next column, centre one past it.
  always_ff @(posedge clk) begin
    if (step) begin
      above_rd_r  <= above_mem[nxt_col];
      centre_rd_r <= centre_mem[nxt_inc[COL_W-1:0]];
    end
  end

  // ---- window registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (step) begin
      above_fwd_val_r  <= above_wr;
      centre_fwd_val_r <= in_data.pixel_in;
      centre_cur_r     <= centre_cur_nxt;
      right_zero_r     <= (nxt_inc >= w_x);
      above_fwd_r      <= wr_en && (nxt_col == col_r);
      centre_fwd_r     <= wr_en && (nxt_inc == col_x);
    end
    if (wr_en && (col_r == '0)) begin
      col0_r <= in_data.pixel_in;
    end
  end

  // ---- frame position and configuration -----------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      left_r   <= '0;
    end else if (cfg_fire) begin
      // restart the frame on any known register; drop unknown indexes
      unique case (cfg_index)
        CFG_FRAME_WIDTH: begin
          width_r <= eff_dim(cfg_data, MAX_WIDTH);
          col_r   <= '0;
          row_r   <= '0;
          left_r  <= '0;
        end
        CFG_FRAME_HEIGHT: begin
          height_r <= eff_dim(cfg_data, MAX_HEIGHT);
          col_r    <= '0;
          row_r    <= '0;
          left_r   <= '0;
        end
        default: begin
        end
      endcase
    end else if (step) begin
      left_r <= (row_r == '0) ? '0 : centre_cur_r;
      if (last_col) begin
        col_r <= '0;
        // advance a row on pixels, close the frame on the last flush
        row_r <= in_data.func ? '0 : (row_r + ROW_W'(1));
      end else begin
        col_r <= col_inc[COL_W-1:0];
      end
    end
  end

  // ---- output register ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.pixel_out <= lap_clamped;
      out_data_r.frame_end <= in_data.func && last_col;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- assertions ---------------------------------------------------------
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while result word is stalled");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_x < w_x)
    else $error("column index beyond frame width");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    EXT_W'(row_r) <= h_x)
    else $error("row index beyond frame height");

  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_data.func && last_col && !cfg_fire) |=> (row_r == '0))
    else $error("frame did not restart after last flush word");

endmodule

`default_nettype wire
